FILE: sv/pfa_pkg.sv
`default_nettype none

package pfa_pkg;

    localparam int WORD_W          = 32;
    localparam int DEF_PAGE_COUNT  = 1024;
    localparam int DEF_PAGE_OFS_W  = 12;
    localparam logic [31:0] BASE_RESET = 32'h0040_0000;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    function automatic logic [4:0] first_zero(input logic [WORD_W-1:0] w);
        logic [4:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

FILE: sv/page_frame_allocator_unit.sv
`default_nettype none

// Channel    Dir  Bits                                    Handshake
// s (item)   in   tuser[0]=kind, tdata[31:0]=free_address  i_s_tvalid / o_s_tready
// m (result) out  tdata[31:0]=page_address, tuser[1:0]=status  o_m_tvalid / i_m_tready
// cfg        in   i_cfg_wdata[31:0]=pool_base             i_cfg_we
//
// Allocate steps: accept, top-level search, summary-word read, used-word
// read-modify-write. Free steps: accept, offset check with both reads, write-back.
// After reset a clearing pass zeroes both memories;
// o_s_tready stays low until it ends.
// A full output register stalls the final step; a new item is taken while a result waits.

module page_frame_allocator_unit
    import pfa_pkg::*;
#(
    parameter int PAGE_COUNT = DEF_PAGE_COUNT,
    parameter int PAGE_OFS_W = DEF_PAGE_OFS_W
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // [31:0] free_address
    input  wire  [0:0]  i_s_tuser,   // [0] kind
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] page_address
    output logic [1:0]  o_m_tuser,   // [1:0] status
    input  wire         i_cfg_we,
    input  wire  [31:0] i_cfg_wdata
);

    localparam int NROWS  = (PAGE_COUNT + WORD_W - 1) / WORD_W;
    localparam int NSUM   = (NROWS + WORD_W - 1) / WORD_W;
    localparam int ROW_W  = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int SUM_W  = (NSUM > 1) ? $clog2(NSUM) : 1;
    localparam int PIDX_W = 10 + SUM_W;
    localparam int UK     = PAGE_COUNT - (NROWS - 1) * WORD_W;
    localparam int SK     = NROWS - (NSUM - 1) * WORD_W;
    localparam logic [WORD_W-1:0] UPAD = (UK == WORD_W) ? '0 : ~((32'd1 << UK) - 32'd1);
    localparam logic [WORD_W-1:0] SPAD = (SK == WORD_W) ? '0 : ~((32'd1 << SK) - 32'd1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_A0   = 3'd2;
    localparam logic [2:0] S_A1   = 3'd3;
    localparam logic [2:0] S_A2   = 3'd4;
    localparam logic [2:0] S_F0   = 3'd5;
    localparam logic [2:0] S_F1   = 3'd6;

    logic [WORD_W-1:0] mem_used [NROWS];
    logic [WORD_W-1:0] mem_sum  [NSUM];

    logic [2:0]        r_state, n_state;
    logic [ROW_W-1:0]  r_clr, n_clr;
    logic [NSUM-1:0]   r_top, n_top;
    logic [31:0]       r_base;
    logic [31:0]       r_addr;
    logic [PIDX_W-1:0] r_pidx, n_pidx;
    logic              r_ovalid, n_ovalid;
    logic [31:0]       r_oaddr, n_oaddr;
    logic [1:0]        r_ostat, n_ostat;
    logic [WORD_W-1:0] r_u_rd, r_s_rd;

    logic              w_u_we, w_u_re, w_s_we, w_s_re;
    logic [ROW_W-1:0]  w_u_wa, w_u_ra;
    logic [SUM_W-1:0]  w_s_wa, w_s_ra;
    logic [WORD_W-1:0] w_u_wd, w_s_wd;

    logic              w_room;
    logic [SUM_W-1:0]  w_top_pos;
    logic [SUM_W-1:0]  w_s;
    logic [4:0]        w_sb, w_b, w_a1_sb;
    logic [ROW_W-1:0]  w_row;
    logic [SUM_W+4:0]  w_a1_row;
    logic [WORD_W-1:0] w_upad, w_spad, w_a1_spad;
    logic [WORD_W-1:0] w_new_used, w_new_sum;
    logic [31:0]       w_offset, w_fidx;
    logic [PIDX_W-1:0] w_apidx;

    always_comb begin
        w_top_pos = '0;
        for (int i = NSUM - 1; i >= 0; i--) begin
            if (!r_top[i]) begin
                w_top_pos = SUM_W'(i);
            end
        end
    end

    assign w_room    = !r_ovalid || i_m_tready;
    assign w_s       = r_pidx[10 +: SUM_W];
    assign w_sb      = r_pidx[9:5];
    assign w_row     = r_pidx[5 +: ROW_W];
    assign w_upad    = (w_row == ROW_W'(NROWS - 1)) ? UPAD : '0;
    assign w_spad    = (w_s == SUM_W'(NSUM - 1)) ? SPAD : '0;
    assign w_a1_spad = w_spad;
    assign w_a1_sb   = first_zero(r_s_rd | w_a1_spad);
    assign w_a1_row  = {w_s, w_a1_sb};
    assign w_b       = first_zero(r_u_rd | w_upad);
    assign w_apidx   = {w_s, w_sb, w_b};
    assign w_offset  = r_addr - r_base;
    assign w_fidx    = w_offset >> PAGE_OFS_W;

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_top      = r_top;
        n_pidx     = r_pidx;
        n_ovalid   = r_ovalid && !i_m_tready;
        n_oaddr    = r_oaddr;
        n_ostat    = r_ostat;
        w_u_we     = 1'b0;
        w_u_re     = 1'b0;
        w_s_we     = 1'b0;
        w_s_re     = 1'b0;
        w_u_wa     = w_row;
        w_u_ra     = w_row;
        w_s_wa     = w_s;
        w_s_ra     = w_s;
        w_u_wd     = '0;
        w_s_wd     = '0;
        w_new_used = r_u_rd | (32'd1 << w_b);
        w_new_sum  = r_s_rd | (32'd1 << w_sb);
        o_s_tready = (r_state == S_IDLE);

        case (r_state)
            S_CLR: begin
                w_u_we = 1'b1;
                w_u_wa = r_clr;
                if ({1'b0, r_clr} < (ROW_W + 1)'(NSUM)) begin
                    w_s_we = 1'b1;
                    w_s_wa = r_clr[SUM_W-1:0];
                end
                if (r_clr == ROW_W'(NROWS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + ROW_W'(1);
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (i_s_tuser[0] == KIND_FREE) ? S_F0 : S_A0;
                end
            end
            S_A0: begin
                if (&r_top) begin
                    if (w_room) begin
                        n_ovalid = 1'b1;
                        n_oaddr  = '0;
                        n_ostat  = ST_FULL;
                        n_state  = S_IDLE;
                    end
                end else begin
                    w_s_re = 1'b1;
                    w_s_ra = w_top_pos;
                    n_pidx = '0;
                    n_pidx[10 +: SUM_W] = w_top_pos;
                    n_state = S_A1;
                end
            end
            S_A1: begin
                w_u_re     = 1'b1;
                w_u_ra     = w_a1_row[ROW_W-1:0];
                n_pidx[9:5] = w_a1_sb;
                n_state    = S_A2;
            end
            S_A2: begin
                if (w_room) begin
                    w_u_we = 1'b1;
                    w_u_wd = w_new_used;
                    if ((w_new_used | w_upad) == '1) begin
                        w_s_we = 1'b1;
                        w_s_wd = w_new_sum;
                        if ((w_new_sum | w_spad) == '1) begin
                            n_top[w_s] = 1'b1;
                        end
                    end
                    n_pidx   = w_apidx;
                    n_ovalid = 1'b1;
                    n_oaddr  = r_base + (32'(w_apidx) << PAGE_OFS_W);
                    n_ostat  = ST_DONE;
                    n_state  = S_IDLE;
                end
            end
            S_F0: begin
                if (w_fidx >= 32'(PAGE_COUNT)) begin
                    if (w_room) begin
                        n_ovalid = 1'b1;
                        n_oaddr  = '0;
                        n_ostat  = ST_OUTSIDE;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_pidx = w_fidx[PIDX_W-1:0];
                    w_u_re = 1'b1;
                    w_u_ra = w_fidx[5 +: ROW_W];
                    w_s_re = 1'b1;
                    w_s_ra = w_fidx[10 +: SUM_W];
                    n_state = S_F1;
                end
            end
            S_F1: begin
                if (w_room) begin
                    w_u_we     = 1'b1;
                    w_u_wd     = r_u_rd & ~(32'd1 << r_pidx[4:0]);
                    w_s_we     = 1'b1;
                    w_s_wd     = r_s_rd & ~(32'd1 << w_sb);
                    n_top[w_s] = 1'b0;
                    n_ovalid   = 1'b1;
                    n_oaddr    = '0;
                    n_ostat    = ST_DONE;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_u_we) begin
            mem_used[w_u_wa] <= w_u_wd;
        end
        if (w_u_re) begin
            r_u_rd <= mem_used[w_u_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_we) begin
            mem_sum[w_s_wa] <= w_s_wd;
        end
        if (w_s_re) begin
            r_s_rd <= mem_sum[w_s_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_top    <= '0;
            r_base   <= BASE_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_top    <= n_top;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx  <= n_pidx;
        r_oaddr <= n_oaddr;
        r_ostat <= n_ostat;
        if (o_s_tready && i_s_tvalid) begin
            r_addr <= i_s_tdata;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_oaddr;
    assign o_m_tuser  = r_ostat;

endmodule

`default_nettype wire
